FILE: rtl/timestamp_reorder_buffer_assert.svh
// Assertion macros used by the checker of the timestamp reorder buffer.
`ifndef TIMESTAMP_REORDER_BUFFER_ASSERT_SVH
`define TIMESTAMP_REORDER_BUFFER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TSRB_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSRB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tsrb_pkg.sv
// Types and constants shared by the timestamp reorder buffer modules.
package tsrb_pkg;

  // Buffer geometry.
  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  // Record field widths.
  localparam int STAMP_W  = 64;
  localparam int COLOR_W  = 7;
  localparam int PID_W    = 22;
  localparam int INDENT_W = 8;
  localparam int HANDLE_W = 16;
  localparam int REC_W    = STAMP_W + 2 * COLOR_W + PID_W + INDENT_W + 2 * HANDLE_W;
  localparam int TDATA_W  = ((REC_W + 7) / 8) * 8;

  // Idle counter and timeout register.
  localparam int TICK_W = 32;
  localparam logic [TICK_W-1:0] TIMEOUT_RST = TICK_W'(100);
  localparam logic [TICK_W-1:0] IDLE_MAX    = '1;

  // Input beat kinds carried on tuser.
  localparam logic CMD_MSG  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic [COLOR_W-1:0]  back;
    logic [COLOR_W-1:0]  fore;
    logic [PID_W-1:0]    pid;
    logic [INDENT_W-1:0] indent;
    logic [HANDLE_W-1:0] name;
    logic [HANDLE_W-1:0] text;
  } pay_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    pay_t               pay;
  } rec_t;

endpackage

FILE: rtl/tsrb_cell.sv
// One storage cell of the record ring: holds a record and takes its neighbor's on a shift.
module tsrb_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  tsrb_pkg::rec_t rec_i,
  output tsrb_pkg::rec_t rec_o
);

  logic [tsrb_pkg::STAMP_W-1:0] stamp_q;
  tsrb_pkg::pay_t               pay_q;

  // A zero stamp marks the slot empty, so only the stamp is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q <= '0;
    end else if (shift_i) begin
      stamp_q <= rec_i.stamp;
    end
  end

  // Payload is meaningful only once a nonzero stamp has been written with it.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      pay_q <= rec_i.pay;
    end
  end

  assign rec_o.stamp = stamp_q;
  assign rec_o.pay   = pay_q;

endmodule

FILE: rtl/timestamp_reorder_buffer.sv
// Top level of the timestamp reorder buffer: record ring, head scanner and control.
//
//   Channel  Direction  Beat contents
//   s_axis   in         tuser: command; tdata: one log record
//   m_axis   out        tdata: one emitted record; tlast: final record of the item
//   cfg      in         data: flush timeout in idle ticks
//
// The SLOTS records circulate through a ring of cells; slot i passes the head in step i.
// A message is accepted in S_IDLE; one ring turn finds its slot (S_MSG_FIND), an evicted
// record is emitted (S_MSG_EMIT) and a second turn writes the new one (S_MSG_WRITE); a tick
// without flush ends in S_IDLE. A flush makes one ring turn per record, plus a final turn.
// A full output register stalls the ring until the waiting beat is taken.
// After reset all slots are empty and the timeout is 100; there is no clearing pass.
module timestamp_reorder_buffer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata bits from 0: stamp, back_color, fore_color, process_id, indent_depth,
  // name_handle, text_handle, zero fill
  input  logic [tsrb_pkg::TDATA_W-1:0]   s_axis_tdata,
  // tuser: command
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata bits from 0: out_stamp, out_back_color, out_fore_color, out_process_id,
  // out_indent, out_name_handle, out_text_handle, zero fill
  output logic [tsrb_pkg::TDATA_W-1:0]   m_axis_tdata,
  // tlast: last_of_run
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tsrb_pkg::TICK_W-1:0]    cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MSG_FIND,
    S_MSG_EMIT,
    S_MSG_WRITE,
    S_FL_SCAN,
    S_FL_EMIT
  } state_e;

  localparam logic [tsrb_pkg::IDX_W-1:0] STEP_LAST = tsrb_pkg::IDX_W'(tsrb_pkg::SLOTS - 1);
  localparam logic [tsrb_pkg::IDX_W-1:0] STEP_ONE  = tsrb_pkg::IDX_W'(1);
  localparam logic [tsrb_pkg::CNT_W-1:0] CNT_ONE   = tsrb_pkg::CNT_W'(1);
  localparam logic [tsrb_pkg::TICK_W-1:0] TICK_ONE = tsrb_pkg::TICK_W'(1);
  localparam int FILL_W = tsrb_pkg::TDATA_W - tsrb_pkg::REC_W;

  // Record layout on tdata, lowest field first.
  function automatic tsrb_pkg::rec_t unpack_rec(input logic [tsrb_pkg::TDATA_W-1:0] d);
    tsrb_pkg::rec_t r;
    {r.pay.text, r.pay.name, r.pay.indent, r.pay.pid, r.pay.fore, r.pay.back, r.stamp} =
      d[tsrb_pkg::REC_W-1:0];
    return r;
  endfunction

  function automatic logic [tsrb_pkg::TDATA_W-1:0] pack_rec(input tsrb_pkg::rec_t r);
    return {{FILL_W{1'b0}}, r.pay.text, r.pay.name, r.pay.indent, r.pay.pid,
            r.pay.fore, r.pay.back, r.stamp};
  endfunction

  state_e                       state_q, state_d;
  logic [tsrb_pkg::IDX_W-1:0]   step_q, step_d;
  logic [tsrb_pkg::IDX_W-1:0]   best_idx_q, best_idx_d;
  logic [tsrb_pkg::IDX_W-1:0]   clr_idx_q, clr_idx_d;
  logic                         clr_vld_q, clr_vld_d;
  logic                         found_q, found_d;
  logic [tsrb_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [tsrb_pkg::TICK_W-1:0]  idle_q, idle_d;
  logic [tsrb_pkg::TICK_W-1:0]  timeout_q;
  logic                         m_valid_q, m_valid_d;
  logic                         m_last_q, m_last_d;
  tsrb_pkg::rec_t               best_q, best_d;
  tsrb_pkg::rec_t               new_q, new_d;
  logic [tsrb_pkg::TDATA_W-1:0] m_data_q, m_data_d;

  tsrb_pkg::rec_t               cell_out [tsrb_pkg::SLOTS];
  tsrb_pkg::rec_t               cell_in  [tsrb_pkg::SLOTS];
  tsrb_pkg::rec_t               head;
  tsrb_pkg::rec_t               wb;
  logic                         shift;
  logic                         first;
  logic                         nz;
  logic                         less;
  logic                         out_free;
  logic [tsrb_pkg::TICK_W-1:0]  idle_inc;
  logic [tsrb_pkg::CNT_W-1:0]   cnt_base;

  // Ring of cells; the head is cell 0 and the modified head record re-enters at the tail.
  for (genvar g = 0; g < tsrb_pkg::SLOTS; g++) begin : g_cell
    if (g == tsrb_pkg::SLOTS - 1) begin : g_tail
      assign cell_in[g] = wb;
    end else begin : g_body
      assign cell_in[g] = cell_out[g+1];
    end
    tsrb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .rec_i  (cell_in[g]),
      .rec_o  (cell_out[g])
    );
  end

  assign head  = cell_out[0];
  assign shift = (state_q == S_MSG_FIND) || (state_q == S_MSG_WRITE) ||
                 (state_q == S_FL_SCAN);

  // Head write-back: store the new record, or empty the slot emitted by the last flush step.
  always_comb begin
    wb = head;
    if (state_q == S_MSG_WRITE && step_q == best_idx_q) begin
      wb = new_q;
    end
    if (state_q == S_FL_SCAN && clr_vld_q && step_q == clr_idx_q) begin
      wb.stamp = '0;
    end
  end

  // Head scanner terms.
  assign first    = (step_q == '0);
  assign nz       = (wb.stamp != '0);
  assign less     = (wb.stamp < best_q.stamp);
  assign cnt_base = first ? '0 : cnt_q;
  assign idle_inc = (idle_q == tsrb_pkg::IDLE_MAX) ? idle_q : idle_q + TICK_ONE;
  assign out_free = !m_valid_q || m_axis_tready;

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    best_idx_d = best_idx_q;
    clr_idx_d  = clr_idx_q;
    clr_vld_d  = clr_vld_q;
    found_d    = found_q;
    cnt_d      = cnt_q;
    idle_d     = idle_q;
    best_d     = best_q;
    new_d      = new_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_last_d   = m_last_q;
    m_data_d   = m_data_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          step_d = '0;
          if (s_axis_tuser == tsrb_pkg::CMD_MSG) begin
            new_d   = unpack_rec(s_axis_tdata);
            idle_d  = '0;
            state_d = S_MSG_FIND;
          end else if (idle_inc > timeout_q) begin
            idle_d    = '0;
            clr_vld_d = 1'b0;
            state_d   = S_FL_SCAN;
          end else begin
            idle_d = idle_inc;
          end
        end
      end
      S_MSG_FIND: begin
        // Smallest stamp wins, empty slots included; ties keep the lower index.
        step_d = step_q + STEP_ONE;
        if (first || less) begin
          best_d     = wb;
          best_idx_d = step_q;
        end
        if (step_q == STEP_LAST) begin
          step_d  = '0;
          state_d = (best_d.stamp != '0) ? S_MSG_EMIT : S_MSG_WRITE;
        end
      end
      S_MSG_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_last_d  = 1'b1;
          m_data_d  = pack_rec(best_q);
          state_d   = S_MSG_WRITE;
        end
      end
      S_MSG_WRITE: begin
        step_d = step_q + STEP_ONE;
        if (step_q == STEP_LAST) begin
          step_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_FL_SCAN: begin
        // Oldest stored record and the number of records still held.
        step_d  = step_q + STEP_ONE;
        cnt_d   = cnt_base + tsrb_pkg::CNT_W'(nz);
        found_d = (first ? 1'b0 : found_q) | nz;
        if (nz && (first || !found_q || less)) begin
          best_d     = wb;
          best_idx_d = step_q;
        end
        if (step_q == STEP_LAST) begin
          step_d = '0;
          if (found_d) begin
            state_d = S_FL_EMIT;
          end else begin
            clr_vld_d = 1'b0;
            state_d   = S_IDLE;
          end
        end
      end
      S_FL_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_last_d  = (cnt_q == CNT_ONE);
          m_data_d  = pack_rec(best_q);
          clr_vld_d = 1'b1;
          clr_idx_d = best_idx_q;
          state_d   = S_FL_SCAN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      step_q     <= '0;
      best_idx_q <= '0;
      clr_idx_q  <= '0;
      clr_vld_q  <= 1'b0;
      found_q    <= 1'b0;
      cnt_q      <= '0;
      idle_q     <= '0;
      m_valid_q  <= 1'b0;
      m_last_q   <= 1'b0;
      m_data_q   <= '0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      best_idx_q <= best_idx_d;
      clr_idx_q  <= clr_idx_d;
      clr_vld_q  <= clr_vld_d;
      found_q    <= found_d;
      cnt_q      <= cnt_d;
      idle_q     <= idle_d;
      m_valid_q  <= m_valid_d;
      m_last_q   <= m_last_d;
      m_data_q   <= m_data_d;
    end
  end

  // Record holding registers.
  always_ff @(posedge clk_i) begin
    best_q   <= best_d;
    new_q    <= new_d;
  end

  // Timeout register; writes are taken in any cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= tsrb_pkg::TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

FILE: rtl/tsrb_checker.sv
// Port-level checks for the timestamp reorder buffer, bound to the top level.
`include "timestamp_reorder_buffer_assert.svh"

module tsrb_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [tsrb_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic                         m_axis_tlast,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o
);

  // A stalled output beat keeps its contents.
  `TSRB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
                    "output beat changed while stalled")

  // Empty slots are never emitted.
  `TSRB_ASSERT_IMPL(a_out_stored, clk_i, rst_ni, m_axis_tvalid,
                    m_axis_tdata[tsrb_pkg::STAMP_W-1:0] != '0,
                    "emitted record has a zero stamp")

  // A message keeps the input closed while the ring is scanned.
  `TSRB_ASSERT_NEXT(a_msg_busy, clk_i, rst_ni,
                    s_axis_tvalid && s_axis_tready && (s_axis_tuser == tsrb_pkg::CMD_MSG),
                    !s_axis_tready, "input ready right after a message beat")

  // The timeout register takes a write in every cycle.
  `TSRB_ASSERT_IMPL(a_cfg_open, clk_i, rst_ni, cfg_valid_i, cfg_ready_o,
                    "configuration write refused")

endmodule

bind timestamp_reorder_buffer tsrb_checker u_tsrb_checker (.*);

FILE: tb/sv/tb.sv
// Self-checking testbench for the timestamp reorder buffer.
`timescale 1ns / 1ps

module tb;

  localparam int SETTLE_CYCLES = 4 * tsrb_pkg::SLOTS + 16;
  localparam int LIMIT_CYCLES  = 2_000_000;

  // Record layout matches the tdata packing: stamp in the lowest bits.
  typedef struct packed {
    logic [tsrb_pkg::HANDLE_W-1:0] text;
    logic [tsrb_pkg::HANDLE_W-1:0] name;
    logic [tsrb_pkg::INDENT_W-1:0] indent;
    logic [tsrb_pkg::PID_W-1:0]    pid;
    logic [tsrb_pkg::COLOR_W-1:0]  fore;
    logic [tsrb_pkg::COLOR_W-1:0]  back;
    logic [tsrb_pkg::STAMP_W-1:0]  stamp;
  } log_rec_t;

  typedef struct {
    log_rec_t rec;
    logic     last;
  } emitted_t;

  // Tracks the slot contents and idle counter and holds the records still due.
  class reorder_scoreboard;
    log_rec_t                    slot_rec[tsrb_pkg::SLOTS];
    logic [tsrb_pkg::TICK_W-1:0] idle_ticks;
    logic [tsrb_pkg::TICK_W-1:0] flush_timeout;
    emitted_t                    due_records[$];
    int errors, n_msgs, n_ticks, n_flushes, n_evicted, n_checked;

    function new();
      foreach (slot_rec[i]) slot_rec[i] = '0;
      idle_ticks    = '0;
      flush_timeout = tsrb_pkg::TIMEOUT_RST;
    endfunction

    function void set_timeout(logic [tsrb_pkg::TICK_W-1:0] value);
      flush_timeout = value;
    endfunction

    function void note_input(logic cmd, log_rec_t r);
      int       sel;
      int       oldest;
      emitted_t e;
      emitted_t flushed[$];
      if (cmd == tsrb_pkg::CMD_MSG) begin
        n_msgs++;
        // Smallest stamp wins; empty slots hold zero, ties go to the lowest index.
        sel = 0;
        for (int i = 1; i < tsrb_pkg::SLOTS; i++)
          if (slot_rec[i].stamp < slot_rec[sel].stamp) sel = i;
        if (slot_rec[sel].stamp != '0) begin
          e.rec  = slot_rec[sel];
          e.last = 1'b1;
          due_records.push_back(e);
          n_evicted++;
        end
        slot_rec[sel] = r;
        idle_ticks    = '0;
      end else begin
        n_ticks++;
        if (idle_ticks != tsrb_pkg::IDLE_MAX) idle_ticks++;
        if (idle_ticks > flush_timeout) begin
          // Drain stored records in ascending stamp order.
          forever begin
            oldest = -1;
            for (int i = 0; i < tsrb_pkg::SLOTS; i++)
              if (slot_rec[i].stamp != '0 &&
                  (oldest < 0 || slot_rec[i].stamp < slot_rec[oldest].stamp)) oldest = i;
            if (oldest < 0) break;
            e.rec  = slot_rec[oldest];
            e.last = 1'b0;
            flushed.push_back(e);
            slot_rec[oldest].stamp = '0;
          end
          if (flushed.size() > 0) begin
            flushed[flushed.size() - 1].last = 1'b1;
            n_flushes++;
          end
          foreach (flushed[i]) due_records.push_back(flushed[i]);
          idle_ticks = '0;
        end
      end
    endfunction

    function void compare(string what, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
    endfunction

    function void check_output(emitted_t got);
      emitted_t want;
      if (due_records.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected record, expected none, got stamp %0h", $time,
                   got.rec.stamp);
        return;
      end
      want = due_records.pop_front();
      n_checked++;
      compare("stamp", want.rec.stamp, got.rec.stamp);
      compare("back_color", want.rec.back, got.rec.back);
      compare("fore_color", want.rec.fore, got.rec.fore);
      compare("process_id", want.rec.pid, got.rec.pid);
      compare("indent", want.rec.indent, got.rec.indent);
      compare("name_handle", want.rec.name, got.rec.name);
      compare("text_handle", want.rec.text, got.rec.text);
      compare("last_of_run", want.last, got.last);
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [tsrb_pkg::TDATA_W-1:0]  s_axis_tdata;
  logic                          s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [tsrb_pkg::TDATA_W-1:0]  m_axis_tdata;
  logic                          m_axis_tlast;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [tsrb_pkg::TICK_W-1:0]   cfg_data_i;

  reorder_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int cycle_count    = 0;

  timestamp_reorder_buffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every output beat is checked against the oldest record due.
  always @(posedge clk_i) begin
    emitted_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.rec  = log_rec_t'(m_axis_tdata[$bits(log_rec_t)-1:0]);
      got.last = m_axis_tlast;
      sb.check_output(got);
    end
  end

  // Stamps favor zero, the maximum and a narrow range so that ties are common.
  function automatic logic [tsrb_pkg::STAMP_W-1:0] random_stamp();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return '1 - tsrb_pkg::STAMP_W'($urandom_range(3));
      3, 4, 5: return tsrb_pkg::STAMP_W'($urandom_range(1, 40));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic log_rec_t random_record(logic [tsrb_pkg::STAMP_W-1:0] stamp);
    log_rec_t r;
    r.stamp  = stamp;
    r.back   = tsrb_pkg::COLOR_W'($urandom);
    r.fore   = tsrb_pkg::COLOR_W'($urandom);
    r.pid    = tsrb_pkg::PID_W'($urandom);
    r.indent = tsrb_pkg::INDENT_W'($urandom);
    r.name   = tsrb_pkg::HANDLE_W'($urandom);
    r.text   = tsrb_pkg::HANDLE_W'($urandom);
    return r;
  endfunction

  // Sends one input beat, with random idle cycles ahead of it.
  task automatic send_item(logic cmd, log_rec_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= tsrb_pkg::TDATA_W'(r);
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(cmd, r);
    items_sent++;
  endtask

  // Holds off the sender until every due record has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.due_records.size() != 0) @(posedge clk_i);
  endtask

  // Timeout writes happen only once the block has gone quiet.
  task automatic write_timeout(logic [tsrb_pkg::TICK_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_timeout(value);
  endtask

  initial begin
    log_rec_t                    r;
    int                          n_burst;
    int                          n_tick;
    int                          idle_send[5];
    int                          idle_recv[5];
    logic [tsrb_pkg::TICK_W-1:0] phase_limit[5];
    idle_send     = '{0, 64, 0, 34, 0};
    idle_recv     = '{0, 0, 64, 34, 0};
    phase_limit   = '{3, 1, tsrb_pkg::IDLE_MAX, 100, 5};
    sb = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = tsrb_pkg::CMD_MSG;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a timeout of one makes every second idle tick flush.
    write_timeout(1);
    // Ticks on an empty buffer: the flush finds nothing.
    repeat (2) send_item(tsrb_pkg::CMD_TICK, random_record(random_stamp()));
    // A zero-stamp record is stored as empty and silently replaced.
    send_item(tsrb_pkg::CMD_MSG, random_record('0));
    r = '1;
    send_item(tsrb_pkg::CMD_MSG, r);
    r = '0;
    r.stamp = 1;
    send_item(tsrb_pkg::CMD_MSG, r);
    send_item(tsrb_pkg::CMD_MSG, random_record(1));
    // Flush: equal stamps by slot index, maximal stamp last.
    repeat (2) send_item(tsrb_pkg::CMD_TICK, random_record(random_stamp()));
    // All slots at the maximal stamp; the next message evicts slot zero.
    repeat (tsrb_pkg::SLOTS) send_item(tsrb_pkg::CMD_MSG, random_record('1));
    send_item(tsrb_pkg::CMD_MSG, random_record(7));

    // Random phases: message bursts followed by tick runs that may reach a flush.
    for (int p = 0; p < 5; p++) begin
      send_idle_pct  = idle_send[p];
      recv_stall_pct = idle_recv[p];
      write_timeout(p == 4 ? tsrb_pkg::TICK_W'($urandom_range(2, 8)) : phase_limit[p]);
      while (items_sent < 20 + 90 * (p + 1)) begin
        n_burst = $urandom_range(1, 20);
        repeat (n_burst) begin
          if ($urandom_range(9) == 0)
            send_item(tsrb_pkg::CMD_TICK, random_record(random_stamp()));
          send_item(tsrb_pkg::CMD_MSG, random_record(random_stamp()));
        end
        if (sb.flush_timeout < 200 && $urandom_range(9) < 6)
          n_tick = int'(sb.flush_timeout) + 1 + $urandom_range(1);
        else
          n_tick = $urandom_range(1, sb.flush_timeout < 200 ? int'(sb.flush_timeout) : 6);
        repeat (n_tick) send_item(tsrb_pkg::CMD_TICK, random_record(random_stamp()));
        if ($urandom_range(19) == 0) drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.errors += sb.due_records.size();
    $display("Sent %0d messages and %0d ticks over five timeout settings and idle mixes.",
             sb.n_msgs, sb.n_ticks);
    $display("Checked %0d records: %0d evictions, %0d non-empty flushes.",
             sb.n_checked, sb.n_evicted, sb.n_flushes);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: timestamp_reorder_buffer.f
+incdir+rtl
rtl/tsrb_pkg.sv
rtl/tsrb_cell.sv
rtl/timestamp_reorder_buffer.sv
rtl/tsrb_checker.sv
tb/sv/tb.sv
